/* rtl/rle_brick_sprite_decoder_assert.svh */
// ----------------------------------------------------------------------------
// rle brick sprite decoder assertion macros
// shared assertion forms for the decoder checker
// ----------------------------------------------------------------------------
`ifndef RLE_BRICK_SPRITE_DECODER_ASSERT_SVH
`define RLE_BRICK_SPRITE_DECODER_ASSERT_SVH

// checked on every edge, reset included
`define RBSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rbsd check failed");

// checked outside reset only
`define RBSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rbsd check failed");

`endif

/* rtl/rbsd_pkg.sv */
// ----------------------------------------------------------------------------
// rbsd package
// types and constants shared by the run-length sprite decoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package rbsd_pkg;

  // bytes of sprite prefix skipped ahead of the brick header
  localparam int unsigned PREFIX_BYTES = 8;
  localparam logic [3:0]  PREFIX_INIT  = 4'(PREFIX_BYTES - 1);

  // run kinds, top two bits of a flag byte
  localparam logic [1:0] KIND_SKIP   = 2'b00;
  localparam logic [1:0] KIND_LIT_A  = 2'b01;
  localparam logic [1:0] KIND_REPEAT = 2'b10;
  localparam logic [1:0] KIND_LIT_B  = 2'b11;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_WIDTH,
    PH_HEIGHT,
    PH_OFFX,
    PH_OFFY,
    PH_LINE,
    PH_FLAG,
    PH_LITERAL,
    PH_REPEAT
  } phase_t;

  // one decoded byte: an acknowledgement or a span of pixels
  typedef struct packed {
    logic        pix;
    logic [14:0] x;
    logic [8:0]  y;
    logic [7:0]  colour;
    logic [5:0]  cnt_m1;
    logic        done;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/rbsd_front.sv */
// ----------------------------------------------------------------------------
// rbsd front end
// parses the coded byte stream and issues one command per accepted byte
// ----------------------------------------------------------------------------
`default_nettype none

module rbsd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          q_ready,
  output logic               q_push,
  output rbsd_pkg::cmd_t     q_cmd
);
  import rbsd_pkg::*;

  logic        sprite_mode;
  phase_t      phase, phase_next;
  logic [3:0]  prefix_left, prefix_left_next;
  logic [7:0]  rows_total, rows_total_next;
  logic [7:0]  origin_x, origin_x_next;
  logic [7:0]  origin_y, origin_y_next;
  logic [7:0]  row_index, row_index_next;
  logic [7:0]  runs_left, runs_left_next;
  logic [6:0]  run_left, run_left_next;
  logic [14:0] cursor_x, cursor_x_next;
  logic        fin;

  logic [7:0]  b;
  logic [7:0]  row_inc;
  logic        last_row;
  logic [7:0]  runs_dec;
  logic [6:0]  run_dec;
  logic [6:0]  count;
  logic        accept;

  assign b        = s_tdata;
  assign s_tready = q_ready;
  assign accept   = s_tvalid && q_ready;
  assign q_push   = accept;
  assign row_inc  = row_index + 8'd1;
  assign last_row = (row_inc >= rows_total);
  assign runs_dec = runs_left - 8'd1;
  assign run_dec  = run_left - 7'd1;
  assign count    = {1'b0, b[5:0]} + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      sprite_mode <= cfg_wr_data;
    end
  end

  always_comb begin
    phase_next       = phase;
    prefix_left_next = prefix_left;
    rows_total_next  = rows_total;
    origin_x_next    = origin_x;
    origin_y_next    = origin_y;
    row_index_next   = row_index;
    runs_left_next   = runs_left;
    run_left_next    = run_left;
    cursor_x_next    = cursor_x;
    fin              = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (sprite_mode && (PREFIX_BYTES > 0)) begin
          prefix_left_next = PREFIX_INIT;
          phase_next = (PREFIX_INIT == 4'd0) ? PH_WIDTH : PH_PREFIX;
        end else begin
          phase_next = PH_HEIGHT;
        end
      end
      PH_PREFIX: begin
        if (prefix_left <= 4'd1) begin
          prefix_left_next = 4'd0;
          phase_next = PH_WIDTH;
        end else begin
          prefix_left_next = prefix_left - 4'd1;
        end
      end
      PH_WIDTH: begin
        phase_next = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        rows_total_next = b;
        phase_next = PH_OFFX;
      end
      PH_OFFX: begin
        origin_x_next = b;
        phase_next = PH_OFFY;
      end
      PH_OFFY: begin
        origin_y_next  = b;
        row_index_next = 8'd0;
        if (rows_total == 8'd0) begin
          fin = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_LINE;
        end
      end
      PH_LINE: begin
        runs_left_next = b;
        cursor_x_next  = 15'd0;
        if (b == 8'd0) begin
          row_index_next = row_inc;
          fin = last_row;
          phase_next = last_row ? PH_IDLE : PH_LINE;
        end else begin
          phase_next = PH_FLAG;
        end
      end
      PH_FLAG: begin
        case (b[7:6])
          KIND_LIT_A, KIND_LIT_B: begin
            run_left_next = count;
            phase_next = PH_LITERAL;
          end
          KIND_REPEAT: begin
            run_left_next = count;
            phase_next = PH_REPEAT;
          end
          default: begin
            // transparent skip ends the run at once
            cursor_x_next  = cursor_x + {8'd0, count};
            runs_left_next = runs_dec;
            if (runs_dec == 8'd0) begin
              row_index_next = row_inc;
              fin = last_row;
              phase_next = last_row ? PH_IDLE : PH_LINE;
            end else begin
              phase_next = PH_FLAG;
            end
          end
        endcase
      end
      PH_LITERAL: begin
        cursor_x_next = cursor_x + 15'd1;
        run_left_next = run_dec;
        if (run_dec == 7'd0) begin
          runs_left_next = runs_dec;
          if (runs_dec == 8'd0) begin
            row_index_next = row_inc;
            fin = last_row;
            phase_next = last_row ? PH_IDLE : PH_LINE;
          end else begin
            phase_next = PH_FLAG;
          end
        end
      end
      PH_REPEAT: begin
        cursor_x_next  = cursor_x + {8'd0, run_left};
        run_left_next  = 7'd0;
        runs_left_next = runs_dec;
        if (runs_dec == 8'd0) begin
          row_index_next = row_inc;
          fin = last_row;
          phase_next = last_row ? PH_IDLE : PH_LINE;
        end else begin
          phase_next = PH_FLAG;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    q_cmd = '0;
    q_cmd.done = fin;
    if (phase == PH_LITERAL || phase == PH_REPEAT) begin
      q_cmd.pix    = 1'b1;
      q_cmd.x      = {7'd0, origin_x} + cursor_x;
      q_cmd.y      = {1'b0, row_index} + {1'b0, origin_y};
      q_cmd.colour = b;
      if (phase == PH_REPEAT) begin
        q_cmd.cnt_m1 = run_dec[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      prefix_left <= 4'd0;
      rows_total  <= 8'd0;
      origin_x    <= 8'd0;
      origin_y    <= 8'd0;
      row_index   <= 8'd0;
      runs_left   <= 8'd0;
      run_left    <= 7'd0;
      cursor_x    <= 15'd0;
    end else if (accept) begin
      phase       <= phase_next;
      prefix_left <= prefix_left_next;
      rows_total  <= rows_total_next;
      origin_x    <= origin_x_next;
      origin_y    <= origin_y_next;
      row_index   <= row_index_next;
      runs_left   <= runs_left_next;
      run_left    <= run_left_next;
      cursor_x    <= cursor_x_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rbsd_fifo.sv */
// ----------------------------------------------------------------------------
// rbsd command queue
// short register queue between the parser and the pixel expander
// ----------------------------------------------------------------------------
`default_nettype none

module rbsd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rbsd_pkg::cmd_t  push_cmd,
  output logic                 ready,
  input  wire logic            pop,
  output logic                 valid,
  output rbsd_pkg::cmd_t       head
);
  import rbsd_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign ready = (fill != (QPTR_W+1)'(QDEPTH));
  assign valid = (fill != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/rbsd_back.sv */
// ----------------------------------------------------------------------------
// rbsd back end
// expands queued commands into result items, one item per cycle while m_tready is high
// ----------------------------------------------------------------------------
`default_nettype none

module rbsd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire rbsd_pkg::cmd_t  q_cmd,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [31:0]          m_tdata,
  output logic                 m_tlast,
  output logic [1:0]           m_tuser
);
  import rbsd_pkg::*;

  logic        busy;
  cmd_t        cur;
  logic [14:0] x_cur;
  logic [5:0]  left;
  logic        final_item;

  assign final_item = (left == 6'd0);
  assign q_pop      = q_valid && (!busy || (m_tready && final_item));

  assign m_tvalid = busy;
  assign m_tdata  = {cur.colour, cur.y, x_cur};
  assign m_tlast  = final_item;
  assign m_tuser  = {cur.done && final_item, cur.pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (busy && m_tready && final_item) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur   <= q_cmd;
      x_cur <= q_cmd.x;
      left  <= q_cmd.cnt_m1;
    end else if (busy && m_tready && !final_item) begin
      x_cur <= x_cur + 15'd1;
      left  <= left - 6'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/rle_brick_sprite_decoder.sv */
// ----------------------------------------------------------------------------
// run-length brick and sprite decoder
// decodes a run-length coded brick byte by byte into positioned pixels
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata[7:0] coded byte
//  m_*       out  m_tvalid/m_tready   tdata x/y/colour, tlast, tuser flags
//  cfg_*     in   cfg_wr_en           cfg_wr_data sprite mode
//
//  a byte is taken every cycle while the two-entry command queue has room
//  a repeat byte of n pixels gives n items, 1 to 64; all
//  other bytes give one item each, so the output stage sets the pace
//  a byte's command is registered in the queue, then in the expander
//  rst is synchronous and clears parser, queue and expander at once
// ----------------------------------------------------------------------------
`default_nettype none

module rle_brick_sprite_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // byte_in[7:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // pos_x[14:0], pos_y[23:15], colour_index[31:24]
  output logic             m_tlast,
  output logic [1:0]       m_tuser    // pixel_valid[0], brick_done[1]
);
  import rbsd_pkg::*;

  logic q_ready;
  logic q_push;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t head;

  rbsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  rbsd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head)
  );

  rbsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

/* rtl/rbsd_chk.sv */
// ----------------------------------------------------------------------------
// rbsd port checker
// watches the decoder ports for result framing and reset behaviour
// ----------------------------------------------------------------------------
`default_nettype none

`include "rle_brick_sprite_decoder_assert.svh"

module rbsd_chk (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tready,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic        m_tlast,
  input  wire logic [1:0]  m_tuser
);

  // nothing left over on the output after reset
  `RBSD_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!m_tvalid && s_tready))

  // brick completion only on the closing item of a byte
  `RBSD_ASSERT(a_done_last, clk, rst, (m_tvalid && m_tuser[1]) |-> m_tlast)

  // an acknowledgement is a lone item with a zero payload
  `RBSD_ASSERT(a_ack_zero, clk, rst, (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == 32'd0)))

  // a stalled item holds
  `RBSD_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

endmodule

bind rle_brick_sprite_decoder rbsd_chk u_rbsd_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire
